@@ rtl/bdlp_pkg.sv @@
// Shared types and constants for the button debouncer with long press.
package bdlp_pkg;

	localparam int FieldWidth = 8;
	localparam int TickWidth = 16;
	localparam int CfgIndexWidth = 2;

	localparam logic [TickWidth-1:0] DebounceReset = 16'd100;
	localparam logic [TickWidth-1:0] LongpressReset = 16'd3000;
	localparam logic [FieldWidth-1:0] EnableReset = 8'd1;

	localparam logic [CfgIndexWidth-1:0] RegDebounceTicks = 2'd0;
	localparam logic [CfgIndexWidth-1:0] RegLongpressTicks = 2'd1;
	localparam logic [CfgIndexWidth-1:0] RegLongpressEnable = 2'd2;

	// per-lane command for one tick
	typedef struct packed {
		logic advance;     // tick accepted this cycle
		logic first;       // first tick after reset
		logic level;       // sampled pin
		logic lp_enable;   // long press may be restarted
	} lane_cmd_t;

	// per-lane findings for one tick
	typedef struct packed {
		logic stable;
		logic changed;
		logic long_pressed;
	} lane_flag_t;

	typedef struct packed {
		logic [FieldWidth-1:0] stable_levels;
		logic [FieldWidth-1:0] changed;
		logic [FieldWidth-1:0] long_pressed;
	} result_t;

endpackage

@@ rtl/bdlp_lane.sv @@
// One channel of the debouncer: edge check, debounce and long-press countdowns.
module bdlp_lane #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bdlp_pkg::lane_cmd_t     cmd,
	input  logic [COUNT_WIDTH-1:0]  db_load,
	input  logic [COUNT_WIDTH-1:0]  lp_load,
	output bdlp_pkg::lane_flag_t    flag
);
	import bdlp_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

	logic                   stable_q;
	logic                   ref_q;
	logic                   armed_q;
	logic [COUNT_WIDTH-1:0] db_cnt_q;
	logic [COUNT_WIDTH-1:0] lp_cnt_q;

	logic                   stable_d;
	logic                   ref_d;
	logic                   armed_d;
	logic [COUNT_WIDTH-1:0] db_cnt_d;
	logic [COUNT_WIDTH-1:0] lp_cnt_d;
	logic                   chg;
	logic                   lp_fire;

	always_comb begin
		stable_d = stable_q;
		ref_d    = ref_q;
		armed_d  = armed_q;
		db_cnt_d = db_cnt_q;
		lp_cnt_d = lp_cnt_q;
		chg      = 1'b0;
		lp_fire  = 1'b0;
		if (cmd.first) begin
			stable_d = cmd.level;
			ref_d    = cmd.level;
			armed_d  = 1'b1;
			db_cnt_d = '0;
			lp_cnt_d = '0;
		end else begin
			// long press steps first
			if (lp_cnt_q != '0) begin
				lp_cnt_d = lp_cnt_q - CountOne;
				lp_fire  = (lp_cnt_q == CountOne);
			end
			if (!armed_q) begin
				if (db_cnt_q <= CountOne) begin
					db_cnt_d = '0;
					ref_d    = cmd.level;
					armed_d  = 1'b1;
					if (cmd.level != stable_q) begin
						stable_d = cmd.level;
						chg      = 1'b1;
						if (cmd.lp_enable)
							lp_cnt_d = lp_load;
					end
				end else begin
					db_cnt_d = db_cnt_q - CountOne;
				end
			end else if (cmd.level != ref_q) begin
				armed_d  = 1'b0;
				db_cnt_d = db_load;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			ref_q    <= 1'b0;
			armed_q  <= 1'b0;
			db_cnt_q <= '0;
			lp_cnt_q <= '0;
		end else if (cmd.advance) begin
			stable_q <= stable_d;
			ref_q    <= ref_d;
			armed_q  <= armed_d;
			db_cnt_q <= db_cnt_d;
			lp_cnt_q <= lp_cnt_d;
		end
	end

	assign flag.stable       = stable_d;
	assign flag.changed      = chg;
	assign flag.long_pressed = lp_fire;

endmodule

@@ rtl/bdlp_merge.sv @@
// Packs lane findings into a result word; output register plus skid slot.
module bdlp_merge #(
	parameter int CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  bdlp_pkg::lane_flag_t [CHANNELS-1:0] flags,
	output logic                                in_stall,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bdlp_pkg::result_t                   result
);
	import bdlp_pkg::*;

	result_t word;
	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;

	for (genvar c = 0; c < FieldWidth; c++) begin : g_pack
		if (c < CHANNELS) begin : g_lane
			assign word.stable_levels[c] = flags[c].stable;
			assign word.changed[c]       = flags[c].changed;
			assign word.long_pressed[c]  = flags[c].long_pressed;
		end else begin : g_none
			assign word.stable_levels[c] = 1'b0;
			assign word.changed[c]       = 1'b0;
			assign word.long_pressed[c]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || !out_stall) begin
			main_v_q <= skid_v_q | accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || !out_stall) begin
			main_q <= skid_v_q ? skid_q : word;
		end else if (accept) begin
			skid_q <= word;
		end
	end

	assign in_stall  = skid_v_q;
	assign out_valid = main_v_q;
	assign result    = main_q;

endmodule

@@ rtl/button_debounce_longpress_core.sv @@
// Top level of the multi-channel button debouncer with long-press detection.
// Each accepted word on the input channel is one millisecond tick holding the raw
// pin level of every channel; each tick yields exactly one result word with the
// debounced levels, a changed mask and a long-press mask. The first tick after
// reset only loads the stable levels and reports no change. A channel whose pin
// leaves its reference level waits debounce_ticks ticks (zero acts as one), then
// samples the pin; a new stable level sets its changed bit and, if that channel's
// longpress_enable bit is set and longpress_ticks is nonzero, starts a long-press
// countdown that reports after longpress_ticks ticks and is never cancelled.
// Rate: one tick per clock cycle while in_stall is low; an accepted result is
// registered in the output register, or in the skid slot on an output stall.
// Each channel has its own lane of counters, all stepping in the accepting cycle;
// the skid slot parts the handshakes; in_stall rises only when two results are held.
// Configuration: writes on the cfg channel are always taken (cfg_ready high);
// index 0 debounce_ticks, 1 longpress_ticks, 2 longpress_enable, 3 ignored.
// Write only while the block is idle. Times beyond COUNT_WIDTH bits saturate.
module button_debounce_longpress_core #(
	parameter int CHANNELS = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bdlp_pkg::FieldWidth-1:0]      pin_levels,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [bdlp_pkg::FieldWidth-1:0]      stable_levels,
	output logic [bdlp_pkg::FieldWidth-1:0]      changed,
	output logic [bdlp_pkg::FieldWidth-1:0]      long_pressed,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bdlp_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [bdlp_pkg::TickWidth-1:0]       cfg_data
);
	import bdlp_pkg::*;

	// largest count a lane counter holds, widened to 32 bits for compares
	localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [TickWidth-1:0]   db_ticks_q;
	logic [TickWidth-1:0]   lp_ticks_q;
	logic [FieldWidth-1:0]  lp_en_q;
	logic                   started_q;

	logic                   accept;
	logic [TickWidth-1:0]   db_eff;
	logic [31:0]            db_wide;
	logic [31:0]            lp_wide;
	logic [COUNT_WIDTH-1:0] db_load;
	logic [COUNT_WIDTH-1:0] lp_load;
	logic                   lp_allowed;

	lane_cmd_t  [CHANNELS-1:0] cmds;
	lane_flag_t [CHANNELS-1:0] flags;
	result_t                   result;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_ticks_q <= DebounceReset;
			lp_ticks_q <= LongpressReset;
			lp_en_q    <= EnableReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegDebounceTicks:   db_ticks_q <= cfg_data;
				RegLongpressTicks:  lp_ticks_q <= cfg_data;
				RegLongpressEnable: lp_en_q    <= cfg_data[FieldWidth-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			started_q <= 1'b0;
		else if (accept)
			started_q <= 1'b1;
	end

	// reload values, zero debounce acts as one, both saturate to the counter
	assign db_eff  = (db_ticks_q == '0) ? TickWidth'(1) : db_ticks_q;
	assign db_wide = {{(32-TickWidth){1'b0}}, db_eff};
	assign lp_wide = {{(32-TickWidth){1'b0}}, lp_ticks_q};
	assign db_load = (db_wide > CountMax) ? CountMax[COUNT_WIDTH-1:0]
	                                      : db_wide[COUNT_WIDTH-1:0];
	assign lp_load = (lp_wide > CountMax) ? CountMax[COUNT_WIDTH-1:0]
	                                      : lp_wide[COUNT_WIDTH-1:0];
	assign lp_allowed = (lp_ticks_q != '0);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		assign cmds[c].advance = accept;
		assign cmds[c].first   = !started_q;
		// channels past the pin word read low and never enable long press
		if (c < FieldWidth) begin : g_pin
			assign cmds[c].level     = pin_levels[c];
			assign cmds[c].lp_enable = lp_en_q[c] && lp_allowed;
		end else begin : g_nopin
			assign cmds[c].level     = 1'b0;
			assign cmds[c].lp_enable = 1'b0;
		end

		bdlp_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmds[c]),
			.db_load(db_load),
			.lp_load(lp_load),
			.flag   (flags[c])
		);
	end

	bdlp_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.flags    (flags),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

	assign stable_levels = result.stable_levels;
	assign changed       = result.changed;
	assign long_pressed  = result.long_pressed;

endmodule

@@ tb/tb_button_debounce_longpress_core.sv @@
// Self-checking testbench for the button debouncer core with long-press detection.
module tb_button_debounce_longpress_core;
	import bdlp_pkg::*;

	// Index 3 has no register behind it; writes there must be dropped.
	localparam logic [CfgIndexWidth-1:0] RegSpare = 2'd3;

	localparam int PlanRows = 30;
	localparam int Phases = 12;
	localparam int PhaseTicks = 120;

	typedef enum logic {OpTick, OpWrite} plan_op_t;

	// One row of the directed plan. Columns: op, reg index, write data, pins,
	// typed flag, typed expectation (stable, changed, long_pressed).
	typedef struct packed {
		plan_op_t op;
		logic [CfgIndexWidth-1:0] index;
		logic [TickWidth-1:0] data;
		logic [FieldWidth-1:0] pins;
		logic typed;
		result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [FieldWidth-1:0] pin_levels = '0;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [TickWidth-1:0] cfg_data = '0;
	logic in_stall;
	logic out_valid;
	logic cfg_ready;
	logic [FieldWidth-1:0] stable_levels;
	logic [FieldWidth-1:0] changed;
	logic [FieldWidth-1:0] long_pressed;

	button_debounce_longpress_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_levels(pin_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stable_levels(stable_levels),
		.changed(changed),
		.long_pressed(long_pressed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ---------------------------------------------------------------------
	// Debouncer state as the predictor sees it. Per-channel bits and counters
	// are indexed by channel, so a tick is a single pass over eight lanes.
	// ---------------------------------------------------------------------
	logic [TickWidth-1:0] debounce_cfg = DebounceReset;
	logic [TickWidth-1:0] longpress_cfg = LongpressReset;
	logic [FieldWidth-1:0] enable_cfg = EnableReset;

	bit loaded = 1'b0;                       // first tick seen
	logic [FieldWidth-1:0] held_level = '0;  // debounced level
	logic [FieldWidth-1:0] ref_level = '0;   // last sampled reference
	logic [FieldWidth-1:0] armed = '0;       // watching for an edge
	logic [TickWidth-1:0] settle_cnt [FieldWidth] = '{default: '0};
	logic [TickWidth-1:0] press_cnt [FieldWidth] = '{default: '0};

	result_t awaited_words [$];  // predicted result words, oldest first
	int errors = 0;
	bit calm = 1'b0;             // suppresses idling on both sides

	plan_row_t plan [PlanRows];

	initial forever #5 clk = ~clk;

	// Advance the debouncer by one tick and return the word it should emit.
	function automatic result_t debounce_step(input logic [FieldWidth-1:0] pins);
		result_t word;
		logic lvl;
		word = '0;
		for (int c = 0; c < FieldWidth; c++) begin
			lvl = pins[c];
			if (!loaded) begin
				// first tick: take the pins as both stable and reference
				held_level[c] = lvl;
				ref_level[c] = lvl;
				armed[c] = 1'b1;
				settle_cnt[c] = '0;
				press_cnt[c] = '0;
			end else begin
				// long-press countdown steps before the debounce logic
				if (press_cnt[c] != 0) begin
					press_cnt[c] = press_cnt[c] - 1'b1;
					if (press_cnt[c] == 0)
						word.long_pressed[c] = 1'b1;
				end
				if (!armed[c]) begin
					if (settle_cnt[c] <= 1) begin
						// wait over: sample the pin as the new reference
						settle_cnt[c] = '0;
						ref_level[c] = lvl;
						if (lvl != held_level[c]) begin
							held_level[c] = lvl;
							word.changed[c] = 1'b1;
							// zero long-press time never starts a countdown
							if (enable_cfg[c] && longpress_cfg != 0)
								press_cnt[c] = longpress_cfg;
						end
						armed[c] = 1'b1;
					end else begin
						settle_cnt[c] = settle_cnt[c] - 1'b1;
					end
				end else if (lvl != ref_level[c]) begin
					// edge: disarm, a zero debounce time still waits one tick
					armed[c] = 1'b0;
					settle_cnt[c] = (debounce_cfg == 0) ? TickWidth'(1) : debounce_cfg;
				end
			end
		end
		loaded = 1'b1;
		word.stable_levels = held_level;
		return word;
	endfunction

	task automatic check_field(input string what, input logic [FieldWidth-1:0] want,
			input logic [FieldWidth-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// Offer one tick word, with a random gap in front. Valid is only dropped
	// when a gap is taken, so back-to-back words keep it high.
	task automatic send_tick(input logic [FieldWidth-1:0] pins, input bit typed,
			input result_t want);
		result_t word;
		if (!calm && $urandom_range(99, 0) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (!calm && $urandom_range(99, 0) < 27)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		pin_levels <= pins;
		do @(posedge clk); while (in_stall);
		word = debounce_step(pins);
		if (typed)
			word = want;
		awaited_words.push_back(word);
	endtask

	// Register write; valid stays up across a burst and drops after the last.
	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
			input logic [TickWidth-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegDebounceTicks: debounce_cfg = data;
			RegLongpressTicks: longpress_cfg = data;
			RegLongpressEnable: enable_cfg = data[FieldWidth-1:0];
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// Stop offering words and wait until every predicted word has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
	endtask

	// Result side: compare each accepted word, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %h %h %h",
					$time, stable_levels, changed, long_pressed);
			end else begin
				check_field("stable_levels", awaited_words[0].stable_levels, stable_levels);
				check_field("changed", awaited_words[0].changed, changed);
				check_field("long_pressed", awaited_words[0].long_pressed, long_pressed);
				void'(awaited_words.pop_front());
			end
		end
		out_stall <= !calm && ($urandom_range(99, 0) < 27);
	end

	initial begin
		plan_row_t row;
		logic [FieldWidth-1:0] intent;
		logic [FieldWidth-1:0] pins;
		logic [TickWidth-1:0] deb_pick;
		logic [TickWidth-1:0] lp_pick;
		logic [FieldWidth-1:0] en_pick;
		int bounce_left [FieldWidth];

		// Directed plan. Rows with a typed word are the ones that are
		// obvious by inspection; the rest go through the predictor.
		plan = '{
			// first tick only loads levels, never reports
			{OpTick,  RegSpare,           16'h0000, 8'hA5, 1'b1, 8'hA5, 8'h00, 8'h00},
			// zero debounce time behaves as one tick
			{OpWrite, RegDebounceTicks,   16'h0000, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegLongpressTicks,  16'h0002, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegLongpressEnable, 16'hC3FF, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegSpare,           16'h1234, 8'h00, 1'b0, 24'h0},
			// every pin flips: all disarm, nothing changes yet
			{OpTick,  RegSpare,           16'h0000, 8'h5A, 1'b1, 8'hA5, 8'h00, 8'h00},
			{OpTick,  RegSpare,           16'h0000, 8'h5A, 1'b1, 8'h5A, 8'hFF, 8'h00},
			{OpTick,  RegSpare,           16'h0000, 8'h5A, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h5A, 1'b1, 8'h5A, 8'h00, 8'hFF},
			// short bounce all high, then settle low
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegLongpressTicks,  16'h0003, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			// enable cleared while countdowns run: they still expire
			{OpWrite, RegLongpressEnable, 16'h0000, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'hFF, 1'b0, 24'h0},
			// zero long-press time: changes start no countdown
			{OpWrite, RegLongpressEnable, 16'h00FF, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegLongpressTicks,  16'h0000, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h00, 1'b0, 24'h0},
			// longest long-press time, two-tick debounce on half the pins
			{OpWrite, RegDebounceTicks,   16'h0002, 8'h00, 1'b0, 24'h0},
			{OpWrite, RegLongpressTicks,  16'hFFFF, 8'h00, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h55, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h55, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h55, 1'b0, 24'h0},
			{OpTick,  RegSpare,           16'h0000, 8'h55, 1'b0, 24'h0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PlanRows; i++) begin
			row = plan[i];
			if (row.op == OpWrite) begin
				// registers move only with the pipeline empty
				if (i == 0 || plan[i-1].op != OpWrite)
					drain_results();
				write_reg(row.index, row.data, i == PlanRows - 1 || plan[i+1].op != OpWrite);
			end else begin
				send_tick(row.pins, row.typed, row.want);
			end
		end

		// Random phases. Pins mostly behave like buttons: a held level that
		// occasionally flips with a short burst of chatter. One tick in ten
		// is plain noise. The longest debounce time comes last, since it
		// leaves channels disarmed for far longer than the run.
		intent = 8'($urandom);
		for (int c = 0; c < FieldWidth; c++)
			bounce_left[c] = 0;
		for (int p = 0; p < Phases; p++) begin
			if (p == 0) begin
				deb_pick = '0;
				lp_pick = 16'd1;
				en_pick = 8'hFF;
			end else if (p == 1) begin
				deb_pick = 16'd1;
				lp_pick = 16'hFFFF;
				en_pick = 8'hFF;
			end else if (p == Phases - 1) begin
				deb_pick = 16'hFFFF;
				lp_pick = 16'($urandom_range(40, 1));
				en_pick = 8'($urandom);
			end else begin
				deb_pick = 16'($urandom_range(12, 1));
				lp_pick = ($urandom_range(4, 0) == 0) ? '0 : 16'($urandom_range(60, 1));
				en_pick = (p == 2) ? 8'h00 : 8'($urandom);
			end
			drain_results();
			// one phase runs flat out on both sides
			calm = (p == 4);
			write_reg(RegDebounceTicks, deb_pick, 1'b0);
			write_reg(RegLongpressTicks, lp_pick, 1'b0);
			// upper data bits are don't-care for the enable mask
			write_reg(RegLongpressEnable, {8'($urandom), en_pick}, 1'b0);
			write_reg(RegSpare, 16'($urandom), 1'b1);
			for (int t = 0; t < PhaseTicks; t++) begin
				if ($urandom_range(9, 0) == 0) begin
					pins = 8'($urandom);
				end else begin
					for (int c = 0; c < FieldWidth; c++) begin
						if ($urandom_range(24, 0) == 0) begin
							intent[c] = ~intent[c];
							bounce_left[c] = $urandom_range(5, 0);
						end
						pins[c] = (bounce_left[c] > 0) ? 1'($urandom) : intent[c];
						if (bounce_left[c] > 0)
							bounce_left[c]--;
					end
				end
				send_tick(pins, 1'b0, '0);
			end
		end

		drain_results();
		calm = 1'b0;
		// catch any stray word that follows the last one
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

endmodule
